// File: rtl/i2p_pkg.sv
// Shared types, operator codes and helper functions of the infix to postfix converter.
package i2p_pkg;

    localparam int CODE_W      = 3;
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = 6;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [1:0]        err_t;

    localparam code_t CODE_PAREN = 3'd0;
    localparam code_t CODE_BRACK = 3'd1;
    localparam code_t CODE_BRACE = 3'd2;
    localparam code_t CODE_PLUS  = 3'd3;
    localparam code_t CODE_MINUS = 3'd4;
    localparam code_t CODE_STAR  = 3'd5;
    localparam code_t CODE_SLASH = 3'd6;

    localparam err_t ERR_NONE           = 2'd0;
    localparam err_t ERR_OVERFLOW       = 2'd1;
    localparam err_t ERR_UNMATCHED_CLOSE = 2'd2;
    localparam err_t ERR_UNMATCHED_OPEN  = 2'd3;

    function automatic logic [1:0] op_rank(code_t c);
        logic [1:0] r;
        if (c < CODE_PLUS) begin
            r = 2'd0;
        end else if (c < CODE_STAR) begin
            r = 2'd1;
        end else begin
            r = 2'd2;
        end
        return r;
    endfunction

    function automatic logic [7:0] code_ascii(code_t c);
        logic [7:0] a;
        case (c)
            CODE_PAREN: a = 8'h28;
            CODE_BRACK: a = 8'h5B;
            CODE_BRACE: a = 8'h7B;
            CODE_PLUS:  a = 8'h2B;
            CODE_MINUS: a = 8'h2D;
            CODE_STAR:  a = 8'h2A;
            CODE_SLASH: a = 8'h2F;
            default:    a = 8'h00;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/i2p_stack_ram.sv
// Operator stack memory: one write port and one read port with registered read data.
module i2p_stack_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  i2p_pkg::code_t      wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output i2p_pkg::code_t      rd_data
);

    i2p_pkg::code_t mem [DEPTH];
    i2p_pkg::code_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/infix_to_postfix_converter_top.sv
// Top level of the shunting-yard infix to postfix converter.
//
// Characters of an infix expression arrive one beat at a time on the s_ channel;
// s_tlast marks the last character of an expression. Postfix tokens leave on the
// m_ channel; m_tlast marks the final beat caused by one input character and
// m_tuser carries the error code, with a zero token on an error beat.
// An input beat that causes no output produces no beat on the m_ channel.
// The operator stack lives in a synchronous memory of STACK_DEPTH entries.
// One character is taken at a time; s_tready rises again only when it is finished.
// Every operator popped takes a memory read and then a compare and emit, and
// the end of an expression flushes the operators left on the stack the same way.
// Tokens pass through a one-deep hold register and the output register, so the
// sequencer only stalls when both are full and the receiver holds m_tready low.
// After reset the stack holds a single opening bracket and no output is pending;
// no clearing pass is needed. After an error, characters are dropped until the
// end of the expression, which restores the start state.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_code
    input  logic       s_tlast,   // end_of_expression
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // token
    output logic       m_tlast,   // last_of_run
    output logic [1:0] m_tuser    // error_code
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int RES_W = i2p_pkg::RES_CNT_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
    localparam logic [RES_W-1:0] RES_MAX = RES_W'(i2p_pkg::MAX_RESULTS);

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_OP_RD    = 4'd2;
    localparam logic [3:0] S_OP_CMP   = 4'd3;
    localparam logic [3:0] S_PUSH     = 4'd4;
    localparam logic [3:0] S_CL_RD    = 4'd5;
    localparam logic [3:0] S_CL_CMP   = 4'd6;
    localparam logic [3:0] S_ERR      = 4'd7;
    localparam logic [3:0] S_AFTER    = 4'd8;
    localparam logic [3:0] S_RESTART  = 4'd9;
    localparam logic [3:0] S_FINISH   = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [7:0]          char_reg, char_next;
    logic                end_reg, end_next;
    i2p_pkg::code_t      code_reg, code_next;
    i2p_pkg::err_t       err_reg, err_next;
    logic                flush_reg, flush_next;
    logic                skip_reg, skip_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                bot_dirty_reg, bot_dirty_next;
    logic                rd_bot_reg, rd_bot_next;
    logic [RES_W-1:0]    res_cnt_reg, res_cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [7:0]          pend_tok_reg, pend_tok_next;
    i2p_pkg::err_t       pend_err_reg, pend_err_next;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          m_tok_reg, m_tok_next;
    i2p_pkg::err_t       m_err_reg, m_err_next;
    logic                m_last_reg, m_last_next;

    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    i2p_pkg::code_t      wr_data, rd_data, top_code;
    logic                emit_req, emit_go, room, capped;
    logic [7:0]          emit_tok;
    i2p_pkg::err_t       emit_err;
    logic [CNT_W-1:0]    cnt_dec;

    i2p_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign top_code = rd_bot_reg ? i2p_pkg::CODE_PAREN : rd_data;
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign room     = !pend_valid_reg || !m_valid_reg || m_tready;
    assign capped   = (res_cnt_reg >= RES_MAX);
    assign emit_go  = capped || room;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tok_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

    always_comb begin
        state_next      = state_reg;
        char_next       = char_reg;
        end_next        = end_reg;
        code_next       = code_reg;
        err_next        = err_reg;
        flush_next      = flush_reg;
        skip_next       = skip_reg;
        cnt_next        = cnt_reg;
        bot_dirty_next  = bot_dirty_reg;
        rd_bot_next     = rd_bot_reg;
        res_cnt_next    = res_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_tok_next   = pend_tok_reg;
        pend_err_next   = pend_err_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_tok_next      = m_tok_reg;
        m_err_next      = m_err_reg;
        m_last_next     = m_last_reg;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[AW-1:0];
        wr_data         = code_reg;
        rd_en           = 1'b0;
        rd_addr         = cnt_dec[AW-1:0];
        emit_req        = 1'b0;
        emit_tok        = 8'h00;
        emit_err        = i2p_pkg::ERR_NONE;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    char_next    = s_tdata;
                    end_next     = s_tlast;
                    res_cnt_next = '0;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (skip_reg) begin
                    state_next = S_AFTER;
                end else if (char_reg >= CH_ZERO && char_reg <= CH_NINE) begin
                    emit_req = 1'b1;
                    emit_tok = char_reg;
                    if (emit_go) begin
                        state_next = S_AFTER;
                    end
                end else begin
                    unique case (char_reg) inside
                        CH_LPAREN: begin
                            code_next  = i2p_pkg::CODE_PAREN;
                            state_next = S_PUSH;
                        end
                        CH_LBRACK: begin
                            code_next  = i2p_pkg::CODE_BRACK;
                            state_next = S_PUSH;
                        end
                        CH_LBRACE: begin
                            code_next  = i2p_pkg::CODE_BRACE;
                            state_next = S_PUSH;
                        end
                        CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
                            state_next = S_CL_RD;
                        end
                        CH_PLUS: begin
                            code_next  = i2p_pkg::CODE_PLUS;
                            state_next = S_OP_RD;
                        end
                        CH_MINUS: begin
                            code_next  = i2p_pkg::CODE_MINUS;
                            state_next = S_OP_RD;
                        end
                        CH_STAR: begin
                            code_next  = i2p_pkg::CODE_STAR;
                            state_next = S_OP_RD;
                        end
                        CH_SLASH: begin
                            code_next  = i2p_pkg::CODE_SLASH;
                            state_next = S_OP_RD;
                        end
                        default: begin
                            state_next = S_AFTER;
                        end
                    endcase
                end
            end
            S_OP_RD: begin
                if (cnt_reg == '0) begin
                    state_next = S_PUSH;
                end else begin
                    rd_en       = 1'b1;
                    rd_bot_next = (cnt_reg == CNT_W'(1)) && !bot_dirty_reg;
                    state_next  = S_OP_CMP;
                end
            end
            S_OP_CMP: begin
                if (top_code > i2p_pkg::CODE_SLASH ||
                    i2p_pkg::op_rank(top_code) < i2p_pkg::op_rank(code_reg)) begin
                    state_next = S_PUSH;
                end else begin
                    emit_req = 1'b1;
                    emit_tok = i2p_pkg::code_ascii(top_code);
                    if (emit_go) begin
                        cnt_next   = cnt_dec;
                        state_next = S_OP_RD;
                    end
                end
            end
            S_PUSH: begin
                if (cnt_reg == DEPTH_C) begin
                    err_next   = i2p_pkg::ERR_OVERFLOW;
                    state_next = S_ERR;
                end else begin
                    wr_en = 1'b1;
                    if (cnt_reg == '0) begin
                        bot_dirty_next = 1'b1;
                    end
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_AFTER;
                end
            end
            S_CL_RD: begin
                if (cnt_reg == '0) begin
                    err_next   = i2p_pkg::ERR_UNMATCHED_CLOSE;
                    state_next = S_ERR;
                end else begin
                    rd_en       = 1'b1;
                    rd_bot_next = (cnt_reg == CNT_W'(1)) && !bot_dirty_reg;
                    state_next  = S_CL_CMP;
                end
            end
            S_CL_CMP: begin
                if (top_code < i2p_pkg::CODE_PLUS) begin
                    cnt_next = cnt_dec;
                    if (!flush_reg) begin
                        state_next = S_AFTER;
                    end else if (cnt_dec != '0) begin
                        err_next   = i2p_pkg::ERR_UNMATCHED_OPEN;
                        state_next = S_ERR;
                    end else begin
                        state_next = S_RESTART;
                    end
                end else begin
                    emit_req = 1'b1;
                    emit_tok = i2p_pkg::code_ascii(top_code);
                    if (emit_go) begin
                        cnt_next   = cnt_dec;
                        state_next = S_CL_RD;
                    end
                end
            end
            S_ERR: begin
                emit_req = 1'b1;
                emit_err = err_reg;
                if (emit_go) begin
                    skip_next  = 1'b1;
                    state_next = S_AFTER;
                end
            end
            S_AFTER: begin
                if (!end_reg) begin
                    state_next = S_FINISH;
                end else if (skip_reg) begin
                    state_next = S_RESTART;
                end else begin
                    flush_next = 1'b1;
                    state_next = S_CL_RD;
                end
            end
            S_RESTART: begin
                cnt_next       = CNT_W'(1);
                bot_dirty_next = 1'b0;
                skip_next      = 1'b0;
                flush_next     = 1'b0;
                state_next     = S_FINISH;
            end
            S_FINISH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    m_tok_next      = pend_tok_reg;
                    m_err_next      = pend_err_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (emit_req && emit_go && !capped) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_tok_next   = pend_tok_reg;
                m_err_next   = pend_err_reg;
                m_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_tok_next   = emit_tok;
            pend_err_next   = emit_err;
            res_cnt_next    = res_cnt_reg + RES_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            flush_reg      <= 1'b0;
            skip_reg       <= 1'b0;
            cnt_reg        <= CNT_W'(1);
            bot_dirty_reg  <= 1'b0;
            rd_bot_reg     <= 1'b0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            flush_reg      <= flush_next;
            skip_reg       <= skip_next;
            cnt_reg        <= cnt_next;
            bot_dirty_reg  <= bot_dirty_next;
            rd_bot_reg     <= rd_bot_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg     <= char_next;
        end_reg      <= end_next;
        code_reg     <= code_next;
        err_reg      <= err_next;
        pend_tok_reg <= pend_tok_next;
        pend_err_reg <= pend_err_next;
        m_tok_reg    <= m_tok_next;
        m_err_reg    <= m_err_next;
        m_last_reg   <= m_last_next;
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DEPTH_C)
        else $error("Stack count exceeds the stack depth.");

    a_res_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= RES_MAX)
        else $error("Result count exceeds the per-character limit.");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("Input accepted while a token is still held back.");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESTART) |=> (cnt_reg == CNT_W'(1) && !skip_reg && !bot_dirty_reg))
        else $error("Stack not returned to its start state.");

    a_no_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("Stack read and write in the same cycle.");
`endif

endmodule
